[hdl/urb_pkg.sv]
// Shared types and codes for the UART receive ring buffer.
package urb_pkg;

  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [2:0] {
    OP_RECEIVE = 3'd0,
    OP_LINE_IDLE = 3'd1,
    OP_GET = 3'd2,
    OP_QUERY = 3'd3,
    OP_FLUSH = 3'd4,
    OP_LINE_ERROR = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_MODE = 1'b0,
    CFG_SIZE_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BURST
  } state_e;

  typedef struct packed {
    logic [2:0]       operation;
    logic [7:0]       rx_byte;
    logic [CNT_W-1:0] max_count;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic [7:0]  used_length;
    logic [7:0]  high_water;
    logic [15:0] error_count;
    logic        last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_issue;
    logic emit;
    logic emit_byte;
    logic emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       want_zero;
    logic       used_zero;
    logic       cnt_one;
    logic       rem_one;
  } status_t;

endpackage

[hdl/uart_rx_ring_buffer.sv]
// Flow: an accepted word is captured, executed in the execute state, and its result is registered for output.
// A new word is accepted only from the idle state, set by the accept/execute sequencer; a burst
// read does one ring store read per byte, and busy stays high until the last read is issued.
// Results are strobed for one cycle; the receiver cannot stall them.
// Reset: asynchronous, active low; pointers, high-water mark and error count clear,
// head_mode resets to live and size_in_use to 256; the ring store is not cleared.
module uart_rx_ring_buffer #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  urb_pkg::in_t                  in_i,
  input  logic                          cfg_we_i,
  input  logic [urb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [urb_pkg::SIZE_W-1:0]    cfg_data_i,
  output logic                          res_strobe_o,
  output urb_pkg::out_t                 res_o
);
  import urb_pkg::*;

  cmd_t    cmd;
  status_t status;

  urb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  urb_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

[hdl/urb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module urb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/urb_ctrl.sv]
// Sequencer for the ring buffer: accept, execute, burst read.
module urb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  urb_pkg::status_t status_i,
  output urb_pkg::cmd_t    cmd_o
);
  import urb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
        if (status_i.op == OP_GET && !status_i.used_zero) begin
          cmd_o.rd_issue  = 1'b1;
          cmd_o.emit_byte = 1'b1;
          if (status_i.want_zero || status_i.cnt_one) begin
            cmd_o.emit_last = 1'b1;
          end else begin
            state_d = ST_BURST;
          end
        end else begin
          cmd_o.emit_last = 1'b1;
        end
      end
      ST_BURST: begin
        cmd_o.rd_issue  = 1'b1;
        cmd_o.emit      = 1'b1;
        cmd_o.emit_byte = 1'b1;
        if (status_i.rem_one) begin
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

[hdl/urb_datapath.sv]
// Pointers, counters, configuration registers, ring store and result registers.
module urb_datapath #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  urb_pkg::in_t                     in_i,
  input  logic                             cfg_we_i,
  input  logic [urb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [urb_pkg::SIZE_W-1:0]       cfg_data_i,
  input  urb_pkg::cmd_t                    cmd_i,
  output urb_pkg::status_t                 status_o,
  output logic                             res_strobe_o,
  output urb_pkg::out_t                    res_o
);
  import urb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;

  // captured word
  logic [2:0]       op_q;
  logic [7:0]       rx_q;
  logic [CNT_W-1:0] want_q;

  logic              head_mode_q;
  logic [SIZE_W-1:0] size_q;
  logic [PTR_W-1:0]  wp_q, vh_q, rp_q;
  logic [7:0]        peak_q;
  logic [15:0]       fault_q;
  logic [CNT_W-1:0]  rem_q;
  logic [7:0]        used_q;
  logic              strobe_q, byte_q, last_q;

  logic [CMP_W-1:0] len, size_x, head_x, rp_x, used, wp_inc, rp_inc;
  logic [PTR_W-1:0] head, wp_next, rp_next;
  logic [7:0]       used_sat;
  logic [CNT_W-1:0] want_c, cnt;
  logic [7:0]       ram_rdata;
  logic             ram_we, peak_upd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_i.operation;
      rx_q   <= in_i.rx_byte;
      want_q <= in_i.max_count;
    end
  end

  // ring length clamped to [2, DEPTH]
  always_comb begin
    size_x = CMP_W'(size_q);
    if (size_x < CMP_W'(2)) begin
      len = CMP_W'(2);
    end else if (size_x > CMP_W'(DEPTH)) begin
      len = CMP_W'(DEPTH);
    end else begin
      len = size_x;
    end
  end

  assign head   = head_mode_q ? wp_q : vh_q;
  assign head_x = CMP_W'(head);
  assign rp_x   = CMP_W'(rp_q);
  assign used   = (head_x >= rp_x) ? (head_x - rp_x) : (head_x + len - rp_x);
  assign used_sat = (used > CMP_W'(255)) ? 8'd255 : used[7:0];

  assign wp_inc  = CMP_W'(wp_q) + CMP_W'(1);
  assign wp_next = (wp_inc >= len) ? '0 : wp_inc[PTR_W-1:0];
  assign rp_inc  = rp_x + CMP_W'(1);
  assign rp_next = (rp_inc >= len) ? '0 : rp_inc[PTR_W-1:0];

  assign want_c = (want_q > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : want_q;
  assign cnt    = (used < CMP_W'(want_c)) ? used[CNT_W-1:0] : want_c;

  assign status_o.op        = op_q;
  assign status_o.want_zero = (want_q == '0);
  assign status_o.used_zero = (used == '0);
  assign status_o.cnt_one   = (cnt == CNT_W'(1));
  assign status_o.rem_one   = (rem_q == CNT_W'(1));

  assign ram_we   = cmd_i.exec && (op_q == OP_RECEIVE);
  assign peak_upd = cmd_i.exec && (op_q == OP_QUERY || (op_q == OP_GET && want_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_mode_q <= 1'b1;
      size_q      <= SIZE_W'(256);
      wp_q        <= '0;
      vh_q        <= '0;
      rp_q        <= '0;
      peak_q      <= '0;
      fault_q     <= '0;
      rem_q       <= '0;
      strobe_q    <= 1'b0;
      byte_q      <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      byte_q   <= cmd_i.emit_byte;
      last_q   <= cmd_i.emit_last;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEAD_MODE: head_mode_q <= cfg_data_i[0];
          CFG_SIZE_IN_USE: begin
            size_q <= cfg_data_i;
            wp_q   <= '0;
            vh_q   <= '0;
            rp_q   <= '0;
          end
          default: ;
        endcase
      end else begin
        if (peak_upd && used_sat > peak_q) begin
          peak_q <= used_sat;
        end
        if (cmd_i.exec) begin
          unique case (op_q)
            OP_RECEIVE: begin
              wp_q <= wp_next;
              if (wp_next == '0 && !head_mode_q) begin
                vh_q <= '0;
              end
            end
            OP_LINE_IDLE: begin
              if (!head_mode_q) begin
                vh_q <= wp_q;
              end
            end
            OP_FLUSH: rp_q <= head;
            OP_LINE_ERROR: begin
              wp_q <= '0;
              vh_q <= '0;
              rp_q <= '0;
              if (fault_q != 16'hFFFF) begin
                fault_q <= fault_q + 16'd1;
              end
            end
            default: ;
          endcase
        end
        if (cmd_i.rd_issue) begin
          rp_q <= rp_next;
        end
        // remaining reads after the first of a burst
        if (cmd_i.exec) begin
          rem_q <= cnt - CNT_W'(1);
        end else if (cmd_i.rd_issue) begin
          rem_q <= rem_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      used_q <= used_sat;
    end
  end

  urb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (rx_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  assign res_strobe_o       = strobe_q;
  assign res_o.data_byte    = byte_q ? ram_rdata : 8'd0;
  assign res_o.data_valid   = byte_q;
  assign res_o.used_length  = used_q;
  assign res_o.high_water   = peak_q;
  assign res_o.error_count  = fault_q;
  assign res_o.last         = last_q;

endmodule
